>>> rtl/bit_vector_alu_macros.svh
// Assertion macros for the ALU top level.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BIT_VECTOR_ALU_MACROS_SVH
`define BIT_VECTOR_ALU_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit_vector_alu: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BVA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit_vector_alu: next-cycle check failed");

// Expression must hold at every edge.
`define BVA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bit_vector_alu: invariant failed");

`endif

>>> rtl/bva_pkg.sv
`default_nettype none

package bva_pkg;

    // Field widths of the words on the ports
    localparam int CMD_W = 4;
    localparam int DATA_W = 32;
    localparam int AMT_W = 6;

    // Operand bits consumed per multiplier step
    localparam int MUL_CHUNK = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_SHL  = 4'd0,
        CMD_SHR  = 4'd1,
        CMD_ASHL = 4'd2,
        CMD_ASHR = 4'd3,
        CMD_ROL  = 4'd4,
        CMD_ROR  = 4'd5,
        CMD_NOT  = 4'd6,
        CMD_INC  = 4'd7,
        CMD_DEC  = 4'd8,
        CMD_ADD  = 4'd9,
        CMD_MUL  = 4'd10,
        CMD_DIV  = 4'd11,
        CMD_AND  = 4'd12,
        CMD_OR   = 4'd13,
        CMD_XOR  = 4'd14
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [AMT_W-1:0]  shift_amount;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [DATA_W-1:0] shifted_out;
        logic              carry_flag;
        logic              divide_error;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic out_load;
    } ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_mul;
        logic start_div;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/bva_ctrl.sv
`default_nettype none

module bva_ctrl #(
    parameter int WIDTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    output logic                op_ready,
    output logic                res_valid,
    input  wire logic           res_ready,
    input  wire bva_pkg::stat_t stat,
    output bva_pkg::ctrl_t      ctrl
);

    localparam int CH = (WIDTH < bva_pkg::MUL_CHUNK) ? WIDTH : bva_pkg::MUL_CHUNK;
    localparam int MUL_STEPS = (WIDTH + CH - 1) / CH;
    localparam int CNT_W = $clog2(WIDTH);

    bva_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic res_valid_reg, res_valid_next;
    logic slot_free;

    // Hold state, step counter and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bva_pkg::ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Sequence one word: load, iterate if needed, then hand the result over
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        slot_free  = !res_valid_reg || res_ready;
        case (state_reg)
            bva_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    ctrl.load = 1'b1;
                    if (stat.start_mul)
                    begin
                        state_next = bva_pkg::ST_MUL;
                        cnt_next   = CNT_W'(MUL_STEPS - 1);
                    end
                    else if (stat.start_div)
                    begin
                        state_next = bva_pkg::ST_DIV;
                        cnt_next   = CNT_W'(WIDTH - 1);
                    end
                    else
                    begin
                        state_next = bva_pkg::ST_EXEC;
                    end
                end
            end
            bva_pkg::ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = bva_pkg::ST_EXEC;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            bva_pkg::ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = bva_pkg::ST_EXEC;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            bva_pkg::ST_EXEC:
            begin
                // Wait until the output register is free or being drained
                if (slot_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = bva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bva_pkg::ST_IDLE;
            end
        endcase
        res_valid_next = ctrl.out_load || (res_valid_reg && !res_ready);
    end

    assign op_ready  = (state_reg == bva_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

>>> rtl/bva_dp.sv
`default_nettype none

module bva_dp #(
    parameter int WIDTH = 32
) (
    input  wire logic              clk,
    input  wire bva_pkg::in_word_t op,
    input  wire bva_pkg::ctrl_t    ctrl,
    output bva_pkg::stat_t         stat,
    output bva_pkg::out_word_t     res
);

    localparam int CH = (WIDTH < bva_pkg::MUL_CHUNK) ? WIDTH : bva_pkg::MUL_CHUNK;
    localparam int ROT_W = $clog2(WIDTH);
    localparam int NS_W = $clog2(WIDTH + 1);
    localparam int AMT_W = bva_pkg::AMT_W;

    logic [WIDTH-1:0] in_a, in_b;

    bva_pkg::op_t cmd_reg, cmd_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [AMT_W-1:0] n_reg, n_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic neg_reg, neg_next;
    bva_pkg::out_word_t res_reg, res_next;

    logic [WIDTH+CH-1:0] prod;
    logic [WIDTH:0] trial;
    logic [WIDTH:0] trial_diff;

    logic [NS_W-1:0] ns;
    logic [ROT_W-1:0] rot;
    logic [2*WIDTH-1:0] wide_l, wide_r, rot_l, rot_r;
    logic [WIDTH-1:0] low_mask, sra, quo;
    logic [WIDTH:0] inc_sum, dec_diff;
    logic [WIDTH-1:0] r_val, r_sh;
    logic r_carry, r_derr;

    assign in_a = WIDTH'(op.operand_a);
    assign in_b = WIDTH'(op.operand_b);

    // Tell the controller which words need the iterative units
    assign stat.start_mul = (op.cmd == bva_pkg::CMD_MUL);
    assign stat.start_div = (op.cmd == bva_pkg::CMD_DIV) && (in_b != '0);

    // One multiplier step: low chunk of y times x, then advance both
    assign prod = (WIDTH + CH)'(x_reg) * (WIDTH + CH)'(y_reg[CH-1:0]);

    // One restoring divide step: shift in the next dividend bit, try subtract
    assign trial      = {rem_reg, q_reg[WIDTH-1]};
    assign trial_diff = trial - {1'b0, d_reg};

    // Load, iterate and capture
    always_comb
    begin
        cmd_next = cmd_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        n_next   = n_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        d_next   = d_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        if (ctrl.load)
        begin
            cmd_next = bva_pkg::op_t'(op.cmd);
            a_next   = in_a;
            b_next   = in_b;
            n_next   = op.shift_amount;
            x_next   = in_a;
            y_next   = in_b;
            acc_next = '0;
            q_next   = in_a[WIDTH-1] ? (~in_a + WIDTH'(1)) : in_a;
            d_next   = in_b[WIDTH-1] ? (~in_b + WIDTH'(1)) : in_b;
            rem_next = '0;
            neg_next = in_a[WIDTH-1] ^ in_b[WIDTH-1];
        end
        if (ctrl.mul_step)
        begin
            acc_next = acc_reg + prod[WIDTH-1:0];
            x_next   = x_reg << CH;
            y_next   = y_reg >> CH;
        end
        if (ctrl.div_step)
        begin
            if (!trial_diff[WIDTH])
            begin
                rem_next = trial_diff[WIDTH-1:0];
                q_next   = {q_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
                q_next   = {q_reg[WIDTH-2:0], 1'b0};
            end
        end
        if (ctrl.out_load)
        begin
            res_next.result_value = bva_pkg::DATA_W'(r_val);
            res_next.shifted_out  = bva_pkg::DATA_W'(r_sh);
            res_next.carry_flag   = r_carry;
            res_next.divide_error = r_derr;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        n_reg   <= n_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // Saturate the shift amount at WIDTH
    always_comb
    begin
        if ({1'b0, n_reg} > (AMT_W + 1)'(WIDTH))
        begin
            ns = NS_W'(WIDTH);
        end
        else
        begin
            ns = NS_W'(n_reg);
        end
    end

    // Rotate amount modulo WIDTH from a constant table
    always_comb
    begin
        rot = '0;
        for (int i = 0; i < (1 << AMT_W); i++)
        begin
            if (n_reg == AMT_W'(i))
            begin
                rot = ROT_W'(i % WIDTH);
            end
        end
    end

    // Shifters, rotators and incrementers on the held operand
    assign wide_l   = {WIDTH'(0), a_reg} << ns;
    assign wide_r   = {a_reg, WIDTH'(0)} >> ns;
    assign low_mask = ~({WIDTH{1'b1}} << ns);
    assign rot_l    = {a_reg, a_reg} << rot;
    assign rot_r    = {a_reg, a_reg} >> rot;
    assign sra      = WIDTH'($signed(a_reg) >>> ns);
    assign inc_sum  = {1'b0, a_reg} + (WIDTH + 1)'(1);
    assign dec_diff = {1'b0, a_reg} - (WIDTH + 1)'(1);
    assign quo      = neg_reg ? (~q_reg + WIDTH'(1)) : q_reg;

    // Select the result fields by opcode
    always_comb
    begin
        r_val   = '0;
        r_sh    = '0;
        r_carry = 1'b0;
        r_derr  = 1'b0;
        case (cmd_reg)
            bva_pkg::CMD_SHL:
            begin
                r_val = wide_l[WIDTH-1:0];
                r_sh  = wide_l[2*WIDTH-1:WIDTH];
            end
            bva_pkg::CMD_ASHL:
            begin
                r_val = {a_reg[WIDTH-1], wide_l[WIDTH-2:0]};
                r_sh  = wide_l[2*WIDTH-1:WIDTH];
            end
            bva_pkg::CMD_SHR:
            begin
                r_val = wide_r[2*WIDTH-1:WIDTH];
                r_sh  = a_reg & low_mask;
            end
            bva_pkg::CMD_ASHR:
            begin
                // A full-width shift clears the value whatever the sign
                r_val = (ns == NS_W'(WIDTH)) ? '0 : sra;
                r_sh  = a_reg & low_mask;
            end
            bva_pkg::CMD_ROL:
            begin
                r_val = rot_l[2*WIDTH-1:WIDTH];
            end
            bva_pkg::CMD_ROR:
            begin
                r_val = rot_r[WIDTH-1:0];
            end
            bva_pkg::CMD_NOT:
            begin
                r_val = ~a_reg;
            end
            bva_pkg::CMD_INC:
            begin
                r_val   = inc_sum[WIDTH-1:0];
                r_carry = inc_sum[WIDTH];
            end
            bva_pkg::CMD_DEC:
            begin
                r_val   = dec_diff[WIDTH-1:0];
                r_carry = (a_reg == '0);
            end
            bva_pkg::CMD_ADD:
            begin
                r_val = a_reg + b_reg;
            end
            bva_pkg::CMD_MUL:
            begin
                r_val = acc_reg;
            end
            bva_pkg::CMD_DIV:
            begin
                if (b_reg == '0)
                begin
                    r_derr = 1'b1;
                end
                else
                begin
                    r_val = quo;
                end
            end
            bva_pkg::CMD_AND:
            begin
                r_val = a_reg & b_reg;
            end
            bva_pkg::CMD_OR:
            begin
                r_val = a_reg | b_reg;
            end
            bva_pkg::CMD_XOR:
            begin
                r_val = a_reg ^ b_reg;
            end
            default:
            begin
                r_val = '0;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/bit_vector_alu.sv
`default_nettype none

// Bit-vector ALU on WIDTH-bit values (ports carry 32-bit fields, zero-extended
// or truncated to WIDTH inside): shifts that also return the bits shifted out,
// rotates, invert, increment and decrement with carry, wrapping add and
// multiply, signed truncating divide with a divide-by-zero flag, and bitwise
// logic. One result word per operation word. A word is loaded, then goes to
// the output stage; multiply first runs the 16-bit-per-step partial product
// multiplier, and divide by a nonzero divisor first runs the restoring
// divider that retires one quotient bit per cycle, while a divide by zero
// skips the divider. A new word is taken only once the last one has reached
// the output stage. A finished result waits in its own output register, so
// the next word is accepted while it is pending; that next word then holds
// in its output stage until the pending result drains.

`include "bit_vector_alu_macros.svh"

module bit_vector_alu #(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               op_valid,
    output logic                    op_ready,
    input  wire bva_pkg::in_word_t  op,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output bva_pkg::out_word_t      res
);

    bva_pkg::ctrl_t ctrl;
    bva_pkg::stat_t stat;

    bva_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    bva_dp #(
        .WIDTH(WIDTH)
    ) u_dp (
        .clk  (clk),
        .op   (op),
        .ctrl (ctrl),
        .stat (stat),
        .res  (res)
    );

    // A load, a multiply step and a divide step never overlap
    `BVA_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({ctrl.load, ctrl.mul_step, ctrl.div_step}))
    // A pending result is never overwritten
    `BVA_ASSERT_SAME(a_no_overwrite, ctrl.out_load, !res_valid || res_ready)
    // The block is busy in the cycle after it takes a word
    `BVA_ASSERT_NEXT(a_busy_after_load, ctrl.load, !op_ready)

endmodule

`default_nettype wire
